### rtl/mkpd_pkg.sv
`default_nettype none

package mkpd_pkg;

   localparam int ROWS        = 4;
   localparam int COLUMNS     = 4;
   localparam int KEYS        = 16;
   localparam int IN_COLS     = 4;
   localparam int ROW_OUT_W   = 4;
   localparam int CFG_W       = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int PHASE_W     = $clog2(2 * ROWS);
   localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;

   localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(2 * ROWS - 1);
   localparam logic [ROWS-1:0]    ROW_ALL    = {ROWS{1'b1}};

   localparam logic [CFG_W-1:0] DEBOUNCE_RESET = CFG_W'(5);
   localparam logic [CFG_W-1:0] HOLD_RESET     = CFG_W'(30);

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_RELOAD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EVENT_HOLD      = CSR_IDX_W'(1);

   typedef struct packed {
      logic [ROW_OUT_W-1:0] row_drive;
      logic [KEYS-1:0]      stable_keys;
      logic [KEYS-1:0]      key_events;
      logic                 aux_stable;
   } result_type;

endpackage

`default_nettype wire

### rtl/matrix_keypad_scan_debounce.sv
// channel | direction | beat                                          | handshake
// req_    | in        | column_levels, aux_level, ack_mask (one tick)  | valid / stall
// rsp_    | out       | row_drive, stable_keys, key_events, aux_stable | valid / stall
// csr_    | in        | index, write data                              | write enable
//
// One tick per cycle while req_stall is low; results are registered before rsp_.
// Per-tick work is one combinational pass from the scan state to the output register.
// Synchronous reset: scan idle with all rows high, config back to 5 and 30.
// A two-entry output buffer absorbs one stall; req_stall rises only when both hold beats.
`default_nettype none

module matrix_keypad_scan_debounce
   import mkpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [IN_COLS-1:0]   req_column_levels,
   input  wire logic                 req_aux_level,
   input  wire logic [KEYS-1:0]      req_ack_mask,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [ROW_OUT_W-1:0]      rsp_row_drive,
   output logic [KEYS-1:0]           rsp_stable_keys,
   output logic [KEYS-1:0]           rsp_key_events,
   output logic                      rsp_aux_stable
);

   logic       accept;
   result_type tick_result;
   result_type rsp_data;

   assign accept = req_valid & ~req_stall;

   mkpd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .column_levels    (req_column_levels),
      .aux_level        (req_aux_level),
      .ack_mask         (req_ack_mask),
      .result           (tick_result)
   );

   mkpd_obuf u_obuf (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .load_data (tick_result),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_row_drive   = rsp_data.row_drive;
   assign rsp_stable_keys = rsp_data.stable_keys;
   assign rsp_key_events  = rsp_data.key_events;
   assign rsp_aux_stable  = rsp_data.aux_stable;

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall without a held result");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (req_stall && !rsp_stall) |=> !req_stall)
      else $error("skid beat not drained");

   a_one_row_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(~rsp_row_drive) <= 1))
      else $error("more than one row driven low");

endmodule

`default_nettype wire

### rtl/mkpd_core.sv
`default_nettype none

module mkpd_core
   import mkpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_write_data,
   input  wire logic                 accept,
   input  wire logic [IN_COLS-1:0]   column_levels,
   input  wire logic                 aux_level,
   input  wire logic [KEYS-1:0]      ack_mask,
   output result_type                result
);

   logic [CFG_W-1:0]   reload_ff, hold_ticks_ff;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ROWS-1:0]    row_pins_ff, row_pins_in;
   logic [KEYS-1:0]    sample_ff, sample_in;
   logic [KEYS-1:0]    stable_ff, stable_in;
   logic [KEYS-1:0]    events_ff, events_in;
   logic [CFG_W-1:0]   deb_cnt_ff, deb_cnt_in;
   logic [CFG_W-1:0]   hold_cnt_ff, hold_cnt_in;
   logic               aux_sample_ff, aux_sample_in;
   logic               aux_state_ff, aux_state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff     <= DEBOUNCE_RESET;
         hold_ticks_ff <= HOLD_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_DEBOUNCE_RELOAD: reload_ff     <= csr_write_data;
            CSR_EVENT_HOLD:      hold_ticks_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic               found;
      logic [ROW_W-1:0]   row_sel;
      logic [KEYS-1:0]    img;
      logic [KEYS-1:0]    fresh;
      logic               aux_now;

      found   = 1'b0;
      row_sel = '0;
      img     = sample_ff;
      fresh   = '0;
      aux_now = ~aux_level;

      events_in     = events_ff & ~ack_mask;
      hold_cnt_in   = (hold_cnt_ff != '0) ? hold_cnt_ff - CFG_W'(1) : hold_cnt_ff;
      phase_in      = (phase_ff != '0) ? phase_ff - PHASE_W'(1) : PHASE_LAST;
      row_pins_in   = row_pins_ff;
      sample_in     = sample_ff;
      stable_in     = stable_ff;
      deb_cnt_in    = deb_cnt_ff;
      aux_sample_in = aux_sample_ff;
      aux_state_in  = aux_state_ff;

      if (phase_in[0]) begin
         row_pins_in = ROW_ALL & ~(ROWS'(1) << phase_in[PHASE_W-1:1]);
      end else begin
         // lowest low row wins
         for (int r = ROWS - 1; r >= 0; r--) begin
            if (!row_pins_ff[r]) begin
               found   = 1'b1;
               row_sel = ROW_W'(r);
            end
         end
         if (found) begin
            for (int c = 0; c < COLUMNS; c++) begin
               for (int r = 0; r < ROWS; r++) begin
                  if (row_sel == ROW_W'(r) && (r + ROWS * c) < KEYS) begin
                     img[r + ROWS * c] = (c < IN_COLS) ? ~column_levels[c] : 1'b0;
                  end
               end
            end
         end
         if (img == sample_ff) begin
            if (deb_cnt_ff != '0) begin
               deb_cnt_in = deb_cnt_ff - CFG_W'(1);
            end else begin
               fresh     = img & ~stable_ff;
               stable_in = img;
               if (fresh != '0) begin
                  events_in   = events_in | fresh;
                  hold_cnt_in = hold_ticks_ff;
               end
               deb_cnt_in = reload_ff;
            end
         end else begin
            deb_cnt_in = reload_ff;
         end
         if (hold_cnt_in == '0) begin
            events_in = '0;
         end
         sample_in = img;
         if (aux_now == aux_sample_ff) begin
            aux_state_in = aux_now;
         end
         aux_sample_in = aux_now;
      end

      result.row_drive   = ROW_OUT_W'(row_pins_in);
      result.stable_keys = stable_in;
      result.key_events  = events_in;
      result.aux_stable  = aux_state_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= '0;
         row_pins_ff   <= ROW_ALL;
         sample_ff     <= '0;
         stable_ff     <= '0;
         events_ff     <= '0;
         deb_cnt_ff    <= '0;
         hold_cnt_ff   <= '0;
         aux_sample_ff <= 1'b0;
         aux_state_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         row_pins_ff   <= row_pins_in;
         sample_ff     <= sample_in;
         stable_ff     <= stable_in;
         events_ff     <= events_in;
         deb_cnt_ff    <= deb_cnt_in;
         hold_cnt_ff   <= hold_cnt_in;
         aux_sample_ff <= aux_sample_in;
         aux_state_ff  <= aux_state_in;
      end
   end

endmodule

`default_nettype wire

### rtl/mkpd_obuf.sv
`default_nettype none

module mkpd_obuf
   import mkpd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  load,
   input  result_type load_data,
   output logic       full,
   output logic       out_valid,
   input  wire logic  out_stall,
   output result_type out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       take;

   assign take      = out_valid_ff & ~out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (load) begin
            out_data_in = load_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (load) begin
         if (out_valid_ff) begin
            skid_data_in  = load_data;
            skid_valid_in = 1'b1;
         end else begin
            out_data_in  = load_data;
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

`default_nettype wire

### tb/tb_matrix_keypad_scan_debounce.sv
`timescale 1ns / 100ps

module tb_matrix_keypad_scan_debounce;
   import mkpd_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;
   logic                 req_valid;
   logic                 req_stall;
   logic [IN_COLS-1:0]   req_column_levels;
   logic                 req_aux_level;
   logic [KEYS-1:0]      req_ack_mask;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ROW_OUT_W-1:0] rsp_row_drive;
   logic [KEYS-1:0]      rsp_stable_keys;
   logic [KEYS-1:0]      rsp_key_events;
   logic                 rsp_aux_stable;

   matrix_keypad_scan_debounce DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_column_levels (req_column_levels),
      .req_aux_level     (req_aux_level),
      .req_ack_mask      (req_ack_mask),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_row_drive     (rsp_row_drive),
      .rsp_stable_keys   (rsp_stable_keys),
      .rsp_key_events    (rsp_key_events),
      .rsp_aux_stable    (rsp_aux_stable)
   );

   always #5 clock = ~clock;

   // scan model state
   logic [PHASE_W-1:0] p_phase;
   logic [ROWS-1:0]    p_rows;
   logic [KEYS-1:0]    p_sample;
   logic [KEYS-1:0]    p_stable;
   logic [KEYS-1:0]    p_events;
   logic [CFG_W-1:0]   p_debounce;
   logic [CFG_W-1:0]   p_hold;
   logic               p_aux_sample;
   logic               p_aux_state;
   logic [CFG_W-1:0]   cfg_debounce;
   logic [CFG_W-1:0]   cfg_hold;

   result_type due_reports[$];

   int ticks_sent = 0;
   int beats_checked = 0;
   int mismatches = 0;
   int settings_used = 0;
   int send_idle_pct = 33;
   int stall_pct = 33;
   bit hold_off_req = 1'b0;

   function automatic int lowest_low_row();
      for (int r = 0; r < ROWS; r++) begin
         if (!p_rows[r]) return r;
      end
      return ROWS;
   endfunction

   // column levels a real keypad shows for the row currently driven
   function automatic logic [IN_COLS-1:0] keypad_columns(input logic [KEYS-1:0] pressed);
      logic [IN_COLS-1:0] cols;
      int r;
      cols = '1;
      r = lowest_low_row();
      if (r < ROWS) begin
         for (int c = 0; c < COLUMNS; c++) begin
            if (pressed[r + ROWS * c]) cols[c] = 1'b0;
         end
      end
      return cols;
   endfunction

   task automatic scan_tick(input logic [IN_COLS-1:0] cols, input logic aux,
                            input logic [KEYS-1:0] ack);
      logic [KEYS-1:0] img;
      logic [KEYS-1:0] fresh;
      logic            aux_now;
      int              r;
      result_type      rep;
      p_events = p_events & ~ack;
      if (p_hold != 0) p_hold = p_hold - 1'b1;
      p_phase = (p_phase == 0) ? PHASE_LAST : p_phase - 1'b1;
      if (p_phase[0]) begin
         p_rows = ROW_ALL;
         p_rows[p_phase[PHASE_W-1:1]] = 1'b0;
      end else begin
         img = p_sample;
         r = lowest_low_row();
         if (r < ROWS) begin
            for (int c = 0; c < COLUMNS; c++) img[r + ROWS * c] = ~cols[c];
         end
         if (img == p_sample) begin
            if (p_debounce != 0) begin
               p_debounce = p_debounce - 1'b1;
            end else begin
               fresh = img & ~p_stable;
               p_stable = img;
               if (fresh != 0) begin
                  p_events = p_events | fresh;
                  p_hold = cfg_hold;
               end
               p_debounce = cfg_debounce;
            end
         end else begin
            p_debounce = cfg_debounce;
         end
         if (p_hold == 0) p_events = '0;
         p_sample = img;
         aux_now = ~aux;
         if (aux_now == p_aux_sample) p_aux_state = aux_now;
         p_aux_sample = aux_now;
      end
      rep.row_drive = p_rows[ROW_OUT_W-1:0];
      rep.stable_keys = p_stable;
      rep.key_events = p_events;
      rep.aux_stable = p_aux_state;
      due_reports.push_back(rep);
   endtask

   task automatic send_tick(input logic [IN_COLS-1:0] cols, input logic aux,
                            input logic [KEYS-1:0] ack);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_column_levels <= cols;
      req_aux_level <= aux;
      req_ack_mask <= ack;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      scan_tick(cols, aux, ack);
      ticks_sent++;
   endtask

   task automatic wait_all_reported();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         CSR_DEBOUNCE_RELOAD: cfg_debounce = val;
         CSR_EVENT_HOLD:      cfg_hold = val;
         default: ;
      endcase
   endtask

   task automatic set_timing(input logic [CFG_W-1:0] reload, input logic [CFG_W-1:0] hold);
      wait_all_reported();
      write_reg(CSR_DEBOUNCE_RELOAD, reload);
      write_reg(CSR_EVENT_HOLD, hold);
      settings_used++;
   endtask

   // presses held over spans sized by cfg_debounce; bounce, glitches and acks mixed in
   task automatic run_keypad(input int count);
      logic [KEYS-1:0]    pressed;
      logic [KEYS-1:0]    ack;
      logic [IN_COLS-1:0] cols;
      logic               aux_hold;
      logic               aux;
      int                 kind, span, bounce, sent, pick;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(0, 11);
         if (kind < 3) pressed = '0;
         else if (kind < 7) pressed = KEYS'(1) << $urandom_range(0, KEYS - 1);
         else if (kind < 9)
            pressed = (KEYS'(1) << $urandom_range(0, KEYS - 1))
                    | (KEYS'(1) << $urandom_range(0, KEYS - 1));
         else pressed = KEYS'($urandom_range(0, 16'hFFFF));
         aux_hold = 1'($urandom_range(0, 1));
         span = 8 + 2 * (int'(cfg_debounce) + 2) + $urandom_range(0, 16);
         if (span > 90) span = 90;
         bounce = $urandom_range(0, 3);
         for (int i = 0; i < span && sent < count; i++) begin
            if (kind == 11 || i < bounce) cols = IN_COLS'($urandom_range(0, 15));
            else cols = keypad_columns(pressed);
            aux = ($urandom_range(0, 9) == 0) ? ~aux_hold : aux_hold;
            pick = $urandom_range(0, 7);
            if (pick == 0) ack = KEYS'($urandom_range(0, 16'hFFFF));
            else if (pick == 1) ack = p_events;
            else ack = '0;
            send_tick(cols, aux, ack);
            sent++;
         end
      end
   endtask

   task automatic test_directed();
      set_timing(8'd0, 8'd4);
      for (int i = 0; i < 8; i++) send_tick(keypad_columns(16'h8001), 1'b0, 16'h0000);
      for (int i = 0; i < 8; i++)
         send_tick(keypad_columns(16'hFFFF), 1'b0, (i >= 6) ? 16'hFFFF : 16'h0000);
      for (int i = 0; i < 4; i++) send_tick(keypad_columns(16'h0000), 1'b1, 16'h0000);
      send_tick(4'h0, 1'b0, 16'hAAAA);
      send_tick(4'hF, 1'b1, 16'h5555);
      send_tick(4'h5, 1'b0, 16'hFFFF);
      send_tick(4'hA, 1'b1, 16'h0000);
   endtask

   task automatic test_default_timing();
      set_timing(DEBOUNCE_RESET, HOLD_RESET);
      run_keypad(140);
   endtask

   task automatic test_no_idle_fast_debounce();
      set_timing(8'd0, 8'd0);
      send_idle_pct = 0;
      stall_pct = 0;
      run_keypad(100);
      send_idle_pct = 33;
      stall_pct = 33;
   endtask

   task automatic test_long_event_hold();
      set_timing(8'd1, 8'd255);
      run_keypad(140);
   endtask

   task automatic test_slow_debounce();
      set_timing(8'd255, 8'd1);
      run_keypad(80);
   endtask

   task automatic test_random_timing();
      set_timing(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 255)));
      run_keypad(70);
      set_timing(CFG_W'($urandom_range(0, 6)), CFG_W'($urandom_range(0, 255)));
      run_keypad(70);
   endtask

   task automatic test_output_backpressure();
      set_timing(8'd2, 8'd20);
      send_idle_pct = 0;
      hold_off_req = 1'b1;
      run_keypad(40);
      send_idle_pct = 33;
   endtask

   // receiver: random stall, plus one long hold-off on request
   initial begin
      int held;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            for (held = 0; held < 60; held++) begin
               rsp_stall <= 1'b1;
               @(negedge clock);
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic check_field(input string name, input logic [KEYS-1:0] want,
                              input logic [KEYS-1:0] got);
      if (got !== want) begin
         if (mismatches < 10)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            if (mismatches < 10) $display("%0t: result beat with nothing expected", $time);
            mismatches++;
         end else begin
            want = due_reports.pop_front();
            check_field("row_drive", KEYS'(want.row_drive), KEYS'(rsp_row_drive));
            check_field("stable_keys", want.stable_keys, rsp_stable_keys);
            check_field("key_events", want.key_events, rsp_key_events);
            check_field("aux_stable", KEYS'(want.aux_stable), KEYS'(rsp_aux_stable));
            beats_checked++;
         end
      end
   end

   initial begin
      #2ms;
      $display("[matrix_keypad_scan_debounce] ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_valid = 1'b0;
      req_column_levels = '0;
      req_aux_level = 1'b0;
      req_ack_mask = '0;
      p_phase = '0;
      p_rows = ROW_ALL;
      p_sample = '0;
      p_stable = '0;
      p_events = '0;
      p_debounce = '0;
      p_hold = '0;
      p_aux_sample = 1'b0;
      p_aux_state = 1'b0;
      cfg_debounce = DEBOUNCE_RESET;
      cfg_hold = HOLD_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_default_timing();
      test_no_idle_fast_debounce();
      test_long_event_hold();
      test_slow_debounce();
      test_random_timing();
      test_output_backpressure();

      wait_all_reported();
      repeat (10) @(posedge clock);
      mismatches += due_reports.size();
      $display("Ran %0d scan ticks over %0d debounce/hold settings, %0d result beats checked,",
               ticks_sent, settings_used, beats_checked);
      $display("with random gaps on both sides and one long output stall; %0d mismatches.",
               mismatches);
      if (mismatches == 0) begin
         $display("[matrix_keypad_scan_debounce] OK");
      end else begin
         $display("[matrix_keypad_scan_debounce] ERROR");
      end
      $finish;
   end

endmodule
